// File: sv/nsq_pkg.sv
// Shared widths, register indexes and reset values for the Newton square root core.
// No dependencies; imported by newton_square_root_core.
package nsq_pkg;

	// Field widths (Q16.16 radicand and root)
	localparam int RADICAND_W = 32;
	localparam int ROOT_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int UPD_W      = 5;

	// Configuration registers
	localparam int MAX_ITER_W  = 5;
	localparam int TOL_SHIFT_W = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_SHIFT = 1'd1;

	localparam logic [MAX_ITER_W-1:0]  MAX_ITER_RST  = 5'd16;
	localparam logic [TOL_SHIFT_W-1:0] TOL_SHIFT_RST = 6'd32;

	// Default cap on Newton updates
	localparam int ITERATION_LIMIT_DEF = 16;

endpackage

// File: sv/newton_square_root_core.sv
// Newton (Heron) square root of an unsigned Q16.16 value, iterative datapath.
// Depends on nsq_pkg for widths, register indexes and reset values.
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    radicand[31:0]
// out       out  out_valid / out_stall  root[31:0], updates_done[4:0], converged
// cfg       in   cfg_we                 cfg_index[0], cfg_data[5:0]
//
// One item at a time. A zero radicand goes from idle straight to the finish state.
// Otherwise each Newton update runs square, difference, compare, a 48-step restoring
// divide and update, plus the final test. The divider yields one bit per cycle.
// arst_n clears control and the config registers. A finished result waits in the
// output register while the next beat is taken; the core only holds in its last
// state if that register is still full.
module newton_square_root_core
	import nsq_pkg::*;
#(
	parameter int ITERATION_LIMIT = ITERATION_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [RADICAND_W-1:0]  radicand,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ROOT_W-1:0]      root,
	output logic [UPD_W-1:0]       updates_done,
	output logic                   converged
);

	localparam int CNT_W     = $clog2(ITERATION_LIMIT + 1);
	localparam int XS_W      = RADICAND_W + FRAC_W;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int DCNT_W    = $clog2(XS_W);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIFF  = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]             state_q;
	logic [MAX_ITER_W-1:0]  max_iterations_q;
	logic [TOL_SHIFT_W-1:0] tolerance_shift_q;

	logic [RADICAND_W-1:0]  x_q;
	logic [XS_W-1:0]        bound_q;
	logic [ROOT_W-1:0]      r_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       limit_q;
	logic                   conv_q;
	logic [SQ_W-1:0]        sq_q;
	logic [SQ_W-1:0]        diff_q;
	logic [ROOT_W-1:0]      rem_q;
	logic [XS_W-1:0]        dq_q;
	logic [DCNT_W-1:0]      div_cnt_q;

	logic                   out_valid_q;
	logic [ROOT_W-1:0]      root_q;
	logic [UPD_W-1:0]       updates_q;
	logic                   converged_q;

	logic                   in_take;
	logic                   out_load;
	logic [CNT_W-1:0]       limit_w;
	logic [XS_W-1:0]        xs_w;
	logic [SQ_W-1:0]        xs_ext_w;
	logic [SQ_W-1:0]        sq_w;
	logic [ROOT_W:0]        rem_sh_w;
	logic                   div_ge_w;
	logic [XS_W:0]          sum_w;
	logic [XS_W-1:0]        half_w;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Clamp the configured update count to the build limit
	always_comb begin
		if (int'(max_iterations_q) > ITERATION_LIMIT) begin
			limit_w = CNT_W'(ITERATION_LIMIT);
		end else begin
			limit_w = CNT_W'(max_iterations_q);
		end
	end

	// Shared arithmetic: square, restoring divide step, halved sum
	assign xs_w     = {x_q, {FRAC_W{1'b0}}};
	assign xs_ext_w = SQ_W'(xs_w);
	assign sq_w     = {{ROOT_W{1'b0}}, r_q} * {{ROOT_W{1'b0}}, r_q};
	assign rem_sh_w = {rem_q, dq_q[XS_W-1]};
	assign div_ge_w = (rem_sh_w >= {1'b0, r_q});
	assign sum_w    = (XS_W+1)'(r_q) + {1'b0, dq_q};
	assign half_w   = sum_w[XS_W:1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iterations_q  <= MAX_ITER_RST;
			tolerance_shift_q <= TOL_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ITERATIONS:  max_iterations_q  <= cfg_data[MAX_ITER_W-1:0];
				CFG_TOLERANCE_SHIFT: tolerance_shift_q <= cfg_data[TOL_SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= (radicand == '0) ? S_DONE : S_CHECK;
					end
				end
				S_CHECK: state_q <= (n_q >= limit_q) ? S_DONE : S_DIFF;
				S_DIFF:  state_q <= S_CMP;
				S_CMP:   state_q <= (diff_q <= SQ_W'(bound_q)) ? S_DONE : S_DIV;
				S_DIV:   state_q <= (div_cnt_q == '0) ? S_UPD : S_DIV;
				S_UPD:   state_q <= S_CHECK;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the iteration
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					x_q     <= radicand;
					bound_q <= {radicand, {FRAC_W{1'b0}}} >> tolerance_shift_q;
					r_q     <= radicand;
					n_q     <= '0;
					limit_q <= limit_w;
					conv_q  <= (radicand == '0);
				end
			end
			S_CHECK: sq_q <= sq_w;
			S_DIFF:  diff_q <= (xs_ext_w >= sq_q) ? (xs_ext_w - sq_q) : (sq_q - xs_ext_w);
			S_CMP: begin
				if (diff_q <= SQ_W'(bound_q)) begin
					conv_q <= 1'b1;
				end
				rem_q     <= '0;
				dq_q      <= xs_w;
				div_cnt_q <= DCNT_W'(XS_W - 1);
			end
			S_DIV: begin
				// one quotient bit per cycle
				rem_q     <= div_ge_w ? ROOT_W'(rem_sh_w - {1'b0, r_q}) : rem_sh_w[ROOT_W-1:0];
				dq_q      <= {dq_q[XS_W-2:0], div_ge_w};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			S_UPD: begin
				// floor((r + q) / 2), saturated to 32 bits; zero guess gives all ones
				if (r_q == '0 || half_w[XS_W-1:ROOT_W] != '0) begin
					r_q <= '1;
				end else begin
					r_q <= half_w[ROOT_W-1:0];
				end
				n_q <= n_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			root_q      <= r_q;
			updates_q   <= UPD_W'(n_q);
			converged_q <= conv_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign root         = root_q;
	assign updates_done = updates_q;
	assign converged    = converged_q;

`ifndef NO_ASSERTIONS
	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> n_q <= limit_q)
		else $error("update count beyond limit");

	a_nonzero_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && radicand != '0 |=> state_q == S_CHECK)
		else $error("nonzero radicand did not start iteration");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside finish state");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> r_q != '0)
		else $error("divide by zero guess");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP && diff_q > SQ_W'(bound_q) |=>
			state_q == S_DIV && div_cnt_q == DCNT_W'(XS_W - 1))
		else $error("divider not started at full count");
`endif

endmodule

// File: verif/nsq_checker.sv
// Scoreboard for newton_square_root_core: tracks the config writes, predicts every root
// from the radicand beats and compares the result beats in order. Depends on nsq_pkg.
module nsq_checker
	import nsq_pkg::*;
#(
	parameter int ITERATION_LIMIT = ITERATION_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [RADICAND_W-1:0] radicand,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [ROOT_W-1:0]     root,
	input  logic [UPD_W-1:0]      updates_done,
	input  logic                  converged,
	output int                    mismatches,
	output int                    roots_pending,
	output int                    roots_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [RADICAND_W-1:0] x;
		logic [ROOT_W-1:0]     root;
		logic [UPD_W-1:0]      updates;
		logic                  conv;
	} root_result_t;

	root_result_t             expected_roots [$];
	logic [MAX_ITER_W-1:0]    cur_max_iter;
	logic [TOL_SHIFT_W-1:0]   cur_shift;

	// Heron iteration in Q16.16, error test done exactly in Q32.32
	function automatic root_result_t predict_root(input logic [RADICAND_W-1:0] x,
			input logic [MAX_ITER_W-1:0] max_iter, input logic [TOL_SHIFT_W-1:0] shift);
		root_result_t res;
		logic [63:0]  xs;
		logic [63:0]  r;
		logic [63:0]  sq;
		logic [63:0]  diff;
		logic [63:0]  quot;
		logic [63:0]  half;
		int           lim;
		int           n;
		res.x = x;
		res.conv = 1'b0;
		xs = {16'd0, x, 16'd0};
		r = {32'd0, x};
		n = 0;
		lim = (int'(max_iter) > ITERATION_LIMIT) ? ITERATION_LIMIT : int'(max_iter);
		if (x == '0) begin
			res.root = '0;
			res.updates = '0;
			res.conv = 1'b1;
			return res;
		end
		while (!res.conv && n < lim) begin
			sq = r * r;
			diff = (xs >= sq) ? xs - sq : sq - xs;
			if (diff <= (xs >> shift)) begin
				res.conv = 1'b1;
			end else begin
				// averaged without overflow, then clipped to 32 bits
				quot = (r == 64'd0) ? {64{1'b1}} : xs / r;
				half = (r >> 1) + (quot >> 1) + {63'd0, r[0] & quot[0]};
				r = (half > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : half;
				n++;
			end
		end
		res.root = r[ROOT_W-1:0];
		res.updates = UPD_W'(n);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		root_result_t want;
		if (!arst_n) begin
			cur_max_iter = MAX_ITER_RST;
			cur_shift = TOL_SHIFT_RST;
			expected_roots.delete();
			mismatches = 0;
			roots_pending = 0;
			roots_checked = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_roots.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: result beat with none expected: root %h updates %0d conv %0b",
							$realtime, root, updates_done, converged);
				end else begin
					want = expected_roots.pop_front();
					roots_checked++;
					if (root !== want.root || updates_done !== want.updates
							|| converged !== want.conv) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%t: radicand %h: expected root %h updates %0d conv %0b",
								$realtime, want.x, want.root, want.updates, want.conv);
							$display("%t: radicand %h: got root %h updates %0d conv %0b",
								$realtime, want.x, root, updates_done, converged);
						end
					end
				end
			end
			// radicand beat: predict with the settings in force
			if (in_valid && !in_stall)
				expected_roots.push_back(predict_root(radicand, cur_max_iter, cur_shift));
			// register writes
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_ITERATIONS)
					cur_max_iter = cfg_data[MAX_ITER_W-1:0];
				else if (cfg_index == CFG_TOLERANCE_SHIFT)
					cur_shift = cfg_data[TOL_SHIFT_W-1:0];
			end
			roots_pending = expected_roots.size();
		end
	end

endmodule

// File: verif/testbench.sv
// Top of the square root core testbench: clock, reset, config writes, radicand stimulus
// and result stall control. Depends on nsq_pkg, newton_square_root_core and nsq_checker.
module testbench;
	import nsq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int ITER_CAP       = ITERATION_LIMIT_DEF;
	localparam int NUM_PHASES     = 10;
	localparam int RAND_PER_PHASE = 105;
	localparam int LONG_HOLD      = 2000;
	localparam int DRAIN_CYCLES   = 1000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [RADICAND_W-1:0] radicand;
	logic                  out_valid;
	logic                  out_stall;
	logic [ROOT_W-1:0]     root;
	logic [UPD_W-1:0]      updates_done;
	logic                  converged;

	int mismatches;
	int roots_pending;
	int roots_checked;
	int sent_count = 0;
	int idle_cycles = 0;

	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	bit hold_req  = 1'b0;

	// iteration cap and tolerance shift per random phase (cap data 48 masks to 16)
	int phase_iter  [NUM_PHASES] = '{16, 1, 8, 48, 4, 0, 16, 12, 3, 31};
	int phase_shift [NUM_PHASES] = '{32, 0, 16, 63, 8, 20, 1, 24, 40, 12};

	newton_square_root_core #(
		.ITERATION_LIMIT(ITER_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.radicand(radicand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root(root),
		.updates_done(updates_done),
		.converged(converged)
	);

	nsq_checker #(
		.ITERATION_LIMIT(ITER_CAP)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.radicand(radicand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root(root),
		.updates_done(updates_done),
		.converged(converged),
		.mismatches(mismatches),
		.roots_pending(roots_pending),
		.roots_checked(roots_checked)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: too long without any beat ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: one long hold-off on request, otherwise random stall bursts when recv_idle is set
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one radicand beat, wait for it to go in, maybe leave a gap after it
	task automatic send_radicand(input logic [RADICAND_W-1:0] x);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		radicand <= x;
		do @(posedge clk); while (in_stall);
		sent_count++;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid and wait until every predicted root has come out
	task automatic wait_all_roots();
		@(negedge clk);
		in_valid <= 1'b0;
		while (roots_pending != 0) @(negedge clk);
	endtask

	task automatic set_regs(input int iter, input int shift);
		write_reg(CFG_MAX_ITERATIONS, CFG_DATA_W'(iter));
		write_reg(CFG_TOLERANCE_SHIFT, CFG_DATA_W'(shift));
	endtask

	// mix of full-range, small, exact squares, near-top, one-hot and zero radicands
	function automatic logic [RADICAND_W-1:0] pick_radicand();
		logic [RADICAND_W-1:0] k;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom();
			3, 4:    return $urandom_range(1, 32'h0003_FFFF);
			5, 6: begin
				k = $urandom_range(1, 65535);
				return k * k;
			end
			7:       return 32'hFFFF_FFFF - $urandom_range(0, 1023);
			8:       return 32'd1 << $urandom_range(0, 31);
			default: return '0;
		endcase
	endfunction

	initial begin
		int p;
		int i;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_ITERATIONS;
		cfg_data = '0;
		in_valid = 1'b0;
		radicand = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero, extremes, exact squares, odd patterns
		send_radicand(32'h0000_0000);
		send_radicand(32'h0000_0001);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0001_0000);
		send_radicand(32'h0004_0000);
		send_radicand(32'h0009_0000);
		send_radicand(32'h8000_0000);
		send_radicand(32'h7FFF_FFFF);
		send_radicand(32'hAAAA_AAAA);
		send_radicand(32'h5555_5555);
		send_radicand(32'h0000_0002);
		wait_all_roots();

		// zero iteration cap: radicand passes through unconverged, zero still converges
		set_regs(0, 0);
		send_radicand(32'h0000_0000);
		send_radicand(32'h0005_0000);
		send_radicand(32'hFFFF_FFFF);
		wait_all_roots();

		// cap above the limit gets clamped; a shift of 63 leaves only exact squares
		set_regs(31, 63);
		send_radicand(32'h0019_0000);
		send_radicand(32'h0002_0000);
		send_radicand(32'hFFFF_0000);
		wait_all_roots();

		// cap of a single update; with shift 0 small radicands converge before any update
		set_regs(1, 0);
		send_radicand(32'h0000_8000);
		send_radicand(32'h1234_5678);
		send_radicand(32'h0000_0001);
		wait_all_roots();

		// random phases, each under its own register setting
		for (p = 0; p < NUM_PHASES; p++) begin
			set_regs(phase_iter[p], phase_shift[p]);
			send_idle = (p % 4 != 3) && (p != NUM_PHASES - 1);
			recv_idle = send_idle;
			if (p == 1) begin
				// results held back while beats keep coming, so the core backs up
				send_idle = 1'b0;
				hold_req = 1'b1;
			end
			for (i = 0; i < RAND_PER_PHASE; i++)
				send_radicand(pick_radicand());
			wait_all_roots();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d radicands under %0d register settings (caps 0 to 31, shifts 0 to 63).",
			sent_count, NUM_PHASES + 4);
		$display("Compared %0d roots, %0d mismatching.", roots_checked, mismatches);
		if (mismatches == 0 && roots_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: newton_square_root_core.f
sv/nsq_pkg.sv
sv/newton_square_root_core.sv
verif/nsq_checker.sv
verif/testbench.sv
